@@ src/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define HRLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define HRLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hrlt_pkg.sv @@
// types and constants of the hashed row lock table
package hrlt_pkg;

    localparam int ROW_W      = 64;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int DIGIT_W    = 8;
    localparam int DIGITS     = ROW_W / DIGIT_W;
    localparam int DIGIT_CW   = $clog2(DIGITS);

    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [STATUS_W-1:0] t_status;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    localparam t_count LIMIT_RESET = 16'hffff;

    typedef struct packed {
        logic   valid;
        t_row   row_id;
        t_count hold;
    } t_slot;

endpackage

@@ src/hrlt_if.sv @@
// request, result and configuration channels
interface hrlt_req_if;
    import hrlt_pkg::*;
    logic valid;
    logic ready;
    logic action;
    t_row row_id;
    modport source(output valid, action, row_id, input ready);
    modport sink(input valid, action, row_id, output ready);
endinterface

interface hrlt_rsp_if;
    import hrlt_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_count  hold_count;
    modport source(output valid, status, hold_count, input ready);
    modport sink(input valid, status, hold_count, output ready);
endinterface

interface hrlt_cfg_if;
    import hrlt_pkg::*;
    logic   valid;
    logic   ready;
    t_count count_limit;
    modport source(output valid, count_limit, input ready);
    modport sink(input valid, count_limit, output ready);
endinterface

@@ src/hrlt_mod.sv @@
// home index unit: row id modulo table size, one byte per cycle
module hrlt_mod #(
    parameter int TABLE_SIZE = 16,
    localparam int HW = $clog2(TABLE_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hrlt_pkg::t_row i_value,
    output logic          o_done,
    output logic [HW-1:0] o_rem
);
    import hrlt_pkg::*;

    localparam int TW = HW + 1;
    localparam logic [TW-1:0] MODULUS = TW'(TABLE_SIZE);

    logic                r_busy;
    logic                r_done;
    logic [DIGIT_CW-1:0] r_cnt;
    t_row                r_val;
    logic [HW-1:0]       r_rem;
    logic [HW-1:0]       n_rem;
    logic [TW-1:0]       step;

    // restoring remainder over the bits of one byte
    always_comb begin
        n_rem = r_rem;
        step  = '0;
        for (int b = 0; b < DIGIT_W; b++) begin
            step = {n_rem, r_val[ROW_W-1-b]};
            if (step >= MODULUS) begin
                step = step - MODULUS;
            end
            n_rem = step[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIGIT_CW'(DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << DIGIT_W;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ src/hrlt_store.sv @@
// slot memory with clearing pass after reset
module hrlt_store #(
    parameter int TABLE_SIZE = 16,
    localparam int DEPTH = TABLE_SIZE * TABLE_SIZE,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output hrlt_pkg::t_slot o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  hrlt_pkg::t_slot i_wr_data,
    output logic            o_clear_busy
);
    import hrlt_pkg::*;

    t_slot         mem [DEPTH];
    t_slot         r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clr_busy;

endmodule

@@ src/hashed_row_lock_table_unit.sv @@
// hashed row lock table: top level with request sequencer and result register
// Reference-counted row holds in TABLE_SIZE buckets of TABLE_SIZE slots.
// i_req carries action (0 acquire, 1 release) and a 64-bit row_id; o_rsp
// returns status and hold_count, exactly one result per request, in order.
// i_cfg writes count_limit (reset 65535) and is always ready; write it only
// while no request is in flight.
// One request is worked at a time. The home index is reckoned one byte
// of row_id a cycle, then the slot memory is probed one slot a cycle,
// k = 1 to PROBE_DEPTH slots, and the found slot is written back unless
// a release finds it empty. A new request is taken the cycle after the
// result is registered.
// After reset the slot memory is cleared, one slot a cycle;
// i_req.ready stays low during that pass.
// A finished result waits in the output register while o_rsp.ready is low;
// the next request is still taken and worked up to its own result.
`include "assert_macros.svh"

module hashed_row_lock_table_unit #(
    parameter int TABLE_SIZE  = 16,
    parameter int PROBE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrlt_req_if.sink   i_req,
    hrlt_rsp_if.source o_rsp,
    hrlt_cfg_if.sink   i_cfg
);
    import hrlt_pkg::*;

    localparam int HW    = $clog2(TABLE_SIZE);
    localparam int DEPTH = TABLE_SIZE * TABLE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(PROBE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    function automatic logic [AW-1:0] slot_addr(input logic [HW-1:0] home,
                                                input logic [HW-1:0] off);
        slot_addr = AW'(AW'(home) * AW'(TABLE_SIZE) + AW'(off));
    endfunction

    logic [2:0]    r_state, n_state;
    logic          r_action;
    t_row          r_row;
    logic [HW-1:0] r_home, n_home;
    logic [HW-1:0] r_off, n_off;
    logic [PW-1:0] r_probe, n_probe;
    t_slot         r_slot, n_slot;
    t_status       r_status, n_status;
    t_count        r_count, n_count;
    t_count        r_limit;
    logic          r_o_valid, n_o_valid;
    t_status       r_o_status, n_o_status;
    t_count        r_o_count, n_o_count;

    logic          req_take;
    logic          mod_done;
    logic [HW-1:0] mod_rem;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_slot         rd_data;
    logic          wr_en;
    logic          clear_busy;
    logic          hit;
    t_count        cur;

    hrlt_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (req_take),
        .i_value (i_req.row_id),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    hrlt_store #(.TABLE_SIZE(TABLE_SIZE)) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_data    (rd_data),
        .i_wr_en      (wr_en),
        .i_wr_addr    (slot_addr(r_home, r_off)),
        .i_wr_data    (r_slot),
        .o_clear_busy (clear_busy)
    );

    assign i_req.ready = (r_state == S_IDLE) && !clear_busy;
    assign req_take    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.hold_count = r_o_count;

    assign hit   = !rd_data.valid || (rd_data.row_id == r_row);
    assign cur   = rd_data.valid ? rd_data.hold : '0;
    assign wr_en = (r_state == S_WRITE);

    always_comb begin
        n_state    = r_state;
        n_home     = r_home;
        n_off      = r_off;
        n_probe    = r_probe;
        n_slot     = r_slot;
        n_status   = r_status;
        n_count    = r_count;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        rd_en      = 1'b0;
        rd_addr    = slot_addr(r_home, r_off);
        unique case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_home  = mod_rem;
                    n_off   = mod_rem;
                    n_probe = '0;
                    rd_en   = 1'b1;
                    rd_addr = slot_addr(mod_rem, mod_rem);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hit) begin
                    n_slot = '{valid: 1'b1, row_id: r_row, hold: cur};
                    if (r_action == ACT_ACQUIRE) begin
                        n_state = S_WRITE;
                        if (cur >= r_limit) begin
                            n_status = ST_OVERFLOW;
                            n_count  = cur;
                        end else begin
                            n_status    = ST_OK;
                            n_count     = cur + 1'b1;
                            n_slot.hold = cur + 1'b1;
                        end
                    end else if (!rd_data.valid) begin
                        n_status = ST_NOT_FOUND;
                        n_count  = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_status    = ST_OK;
                        n_count     = (cur == '0) ? '0 : cur - 1'b1;
                        n_slot.hold = (cur == '0) ? '0 : cur - 1'b1;
                        n_state     = S_WRITE;
                    end
                end else if (r_probe == PW'(PROBE_DEPTH - 1)) begin
                    n_status = (r_action == ACT_ACQUIRE) ? ST_FULL : ST_NOT_FOUND;
                    n_count  = '0;
                    n_state  = S_DONE;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_off   = (r_off == HW'(TABLE_SIZE - 1)) ? '0 : r_off + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = slot_addr(r_home, n_off);
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_limit   <= LIMIT_RESET;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.count_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_action <= i_req.action;
            r_row    <= i_req.row_id;
        end
        r_home     <= n_home;
        r_off      <= n_off;
        r_probe    <= n_probe;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_count    <= n_count;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
    end

    `HRLT_ASSERT_NOW(a_no_req_in_clear, i_clk, i_rst_n, clear_busy, !i_req.ready, "request taken during clear")
    `HRLT_ASSERT_NEXT(a_one_req_at_a_time, i_clk, i_rst_n, req_take, !i_req.ready, "second request taken while busy")
    `HRLT_ASSERT_NOW(a_miss_zero_count, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status == ST_FULL || o_rsp.status == ST_NOT_FOUND), o_rsp.hold_count == '0, "miss result with nonzero count")

endmodule
